// ===== rtl/core/dual_quad_corner_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Dual quad corner tracker assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DUAL_QUAD_CORNER_TRACKER_DEFINES_SVH
`define DUAL_QUAD_CORNER_TRACKER_DEFINES_SVH

// same-cycle implication
`define DQCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dqct assertion failed");

// next-cycle implication
`define DQCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqct assertion failed");

`endif

// ===== rtl/core/dqct_pkg.sv =====
// ----------------------------------------------------------------------------
// dqct_pkg
// Shared constants and types of the dual quad corner tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dqct_pkg;

  localparam int HIST_DEPTH  = 32;
  localparam int FILL_W      = $clog2(HIST_DEPTH + 1);
  localparam int COORD_BITS  = 12;
  localparam int FIELD_BITS  = 12;
  localparam int Q_BITS      = 16;

  localparam logic [FIELD_BITS-1:0] COORD_MASK = FIELD_BITS'((1 << COORD_BITS) - 1);
  localparam logic [15:0] ALPHA_ONE = 16'h8000;

  localparam logic [7:0] REG_WINDOW    = 8'd0;
  localparam logic [7:0] REG_ALPHA     = 8'd1;
  localparam logic [7:0] REG_FRAMES    = 8'd2;
  localparam logic [7:0] REG_THRESHOLD = 8'd3;

  typedef struct packed {
    logic        present;
    logic        held;
    logic [63:0] xs;
    logic [63:0] ys;
  } quad_res_t;

  typedef struct packed {
    logic [7:0]  window;
    logic [15:0] alpha;
  } quad_cfg_t;

endpackage

// ===== rtl/core/dqct_quad.sv =====
// ----------------------------------------------------------------------------
// dqct_quad
// One quad: eight EMA lanes, miss counter and hold/drop decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dqct_quad import dqct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        update,
  input  quad_cfg_t   cfg,
  input  logic        found,
  input  logic [47:0] corner_xs,
  input  logic [47:0] corner_ys,
  output quad_res_t   res
);

  logic [Q_BITS-1:0] smooth [8];
  logic [Q_BITS-1:0] smooth_next [8];
  logic              valid;
  logic              valid_next;
  logic [7:0]        miss;
  logic [7:0]        miss_next;

  always_comb begin
    logic [Q_BITS-1:0]        nq [8];
    logic signed [Q_BITS:0]   diff [8];
    logic signed [2*Q_BITS+1:0] prod [8];
    logic signed [2*Q_BITS+1:0] acc [8];
    logic [7:0]               miss_inc;
    logic [15:0]              a_sat;
    a_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    for (int i = 0; i < 4; i++) begin
      nq[i]     = {corner_xs[FIELD_BITS*i +: FIELD_BITS] & COORD_MASK, 4'b0000};
      nq[i + 4] = {corner_ys[FIELD_BITS*i +: FIELD_BITS] & COORD_MASK, 4'b0000};
    end
    for (int i = 0; i < 8; i++) begin
      diff[i] = $signed({1'b0, nq[i]}) - $signed({1'b0, smooth[i]});
      prod[i] = diff[i] * $signed({1'b0, a_sat});
      acc[i]  = $signed({3'b000, smooth[i], 15'd0}) + prod[i] + 34'sd16384;
    end
    miss_inc   = (miss == 8'hFF) ? miss : miss + 8'd1;
    valid_next = valid;
    miss_next  = miss_inc;
    res.present = 1'b0;
    res.held    = 1'b0;
    for (int i = 0; i < 8; i++) begin
      smooth_next[i] = smooth[i];
    end
    if (found) begin
      miss_next   = 8'd0;
      valid_next  = 1'b1;
      res.present = 1'b1;
      for (int i = 0; i < 8; i++) begin
        smooth_next[i] = valid ? acc[i][30:15] : nq[i];
      end
    end else if (miss_inc > cfg.window) begin
      valid_next = 1'b0;
    end else if (valid) begin
      res.present = 1'b1;
      res.held    = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      res.xs[16*i +: 16] = res.present ? smooth_next[i] : 16'd0;
      res.ys[16*i +: 16] = res.present ? smooth_next[i + 4] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      miss  <= 8'd0;
      for (int i = 0; i < 8; i++) begin
        smooth[i] <= '0;
      end
    end else if (update) begin
      valid <= valid_next;
      miss  <= miss_next;
      for (int i = 0; i < 8; i++) begin
        smooth[i] <= smooth_next[i];
      end
    end
  end

endmodule

// ===== rtl/core/dqct_calib.sv =====
// ----------------------------------------------------------------------------
// dqct_calib
// Success history, running success count and calibration lock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_quad_corner_tracker_defines.svh"

module dqct_calib import dqct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       update,
  input  logic       both,
  input  logic [6:0] frames,
  input  logic [8:0] threshold,
  output logic       lock_flag,
  output logic       lock_now
);

  logic [HIST_DEPTH-1:0] hist;
  logic [HIST_DEPTH-1:0] hist_next;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_next;
  logic [FILL_W-1:0]     count;
  logic [FILL_W-1:0]     count_next;

  always_comb begin
    logic full;
    logic drop;
    full       = (fill >= FILL_W'(HIST_DEPTH));
    drop       = full & hist[HIST_DEPTH-1];
    fill_next  = full ? fill : fill + FILL_W'(1);
    hist_next  = {hist[HIST_DEPTH-2:0], both};
    count_next = count - FILL_W'(drop) + FILL_W'(both);
    lock_now   = both && (7'(fill_next) >= frames) &&
                 ((15'(count_next) << 8) >= (15'(threshold) * 15'(fill_next)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist      <= '0;
      fill      <= '0;
      count     <= '0;
      lock_flag <= 1'b0;
    end else if (update) begin
      hist      <= hist_next;
      fill      <= fill_next;
      count     <= count_next;
      lock_flag <= lock_now;
    end
  end

  `DQCT_ASSERT_NEXT(a_lock_sticky, lock_flag, lock_flag)
  `DQCT_ASSERT_IMP(a_count_in_fill, 1'b1, count <= fill)
  `DQCT_ASSERT_NEXT(a_hist_frozen, lock_flag, $stable(hist) && $stable(count))

endmodule

// ===== rtl/core/dual_quad_corner_tracker.sv =====
// ----------------------------------------------------------------------------
// dual_quad_corner_tracker
// Smooths, holds and drops two detected quads per frame and locks on success.
// ----------------------------------------------------------------------------
// One request per frame enters an input register; when the result register is free,
// the two quad units (eight EMA multiply lanes each) and the calibration unit update
// their state and load the result register, unless calibration is locked. Throughput
// is one request per cycle while the result is not stalled; a stalled result
// holds while one more request waits in the input register.
`timescale 1ns / 1ps
`include "dual_quad_corner_tracker_defines.svh"

module dual_quad_corner_tracker import dqct_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // top_corner_xs, top_corner_ys, bottom_corner_xs, bottom_corner_ys
  input  logic [191:0] s_tdata,
  // top_found, bottom_found
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // top_out_xs, top_out_ys, bottom_out_xs, bottom_out_ys, split_row
  output logic [271:0] m_tdata,
  // top_present, top_held, bottom_present, bottom_held, split_known, locked
  output logic [5:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [7:0]  window;
  logic [15:0] alpha;
  logic [6:0]  frames;
  logic [8:0]  threshold;

  logic         in_valid;
  logic [1:0]   in_found;
  logic [191:0] in_coords;
  logic         advance;
  logic         update;

  quad_cfg_t qcfg;
  quad_res_t top_res;
  quad_res_t bot_res;
  logic      both;
  logic      lock_flag;
  logic      lock_now;

  logic [15:0] split_value;
  logic        split_valid;
  logic [15:0] split_next;
  logic        split_valid_next;

  quad_res_t   out_top;
  quad_res_t   out_bot;
  logic        out_split_known;
  logic [15:0] out_split_row;
  logic        out_locked;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= 8'd5;
      alpha     <= 16'd10923;
      frames    <= 7'd10;
      threshold <= 9'd205;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW:    window    <= cfg_data[7:0];
        REG_ALPHA:     alpha     <= cfg_data;
        REG_FRAMES:    frames    <= cfg_data[6:0];
        REG_THRESHOLD: threshold <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign update   = advance && !lock_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_found  <= s_tuser;
      in_coords <= s_tdata;
    end
  end

  assign qcfg.window = window;
  assign qcfg.alpha  = alpha;

  dqct_quad u_top (
    .clk       (clk),
    .rst       (rst),
    .update    (update),
    .cfg       (qcfg),
    .found     (in_found[0]),
    .corner_xs (in_coords[47:0]),
    .corner_ys (in_coords[95:48]),
    .res       (top_res)
  );

  dqct_quad u_bot (
    .clk       (clk),
    .rst       (rst),
    .update    (update),
    .cfg       (qcfg),
    .found     (in_found[1]),
    .corner_xs (in_coords[143:96]),
    .corner_ys (in_coords[191:144]),
    .res       (bot_res)
  );

  assign both = top_res.present && bot_res.present;

  dqct_calib u_calib (
    .clk       (clk),
    .rst       (rst),
    .update    (update),
    .both      (both),
    .frames    (frames),
    .threshold (threshold),
    .lock_flag (lock_flag),
    .lock_now  (lock_now)
  );

  always_comb begin
    logic [17:0] sum;
    sum = 18'(top_res.ys[15:0]) + 18'(top_res.ys[47:32]) +
          18'(bot_res.ys[15:0]) + 18'(bot_res.ys[47:32]) + 18'd2;
    split_next       = both ? sum[17:2] : split_value;
    split_valid_next = split_valid || both;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split_value <= 16'd0;
      split_valid <= 1'b0;
    end else if (update) begin
      split_value <= split_next;
      split_valid <= split_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // once locked, hold the locking result as payload
  always_ff @(posedge clk) begin
    if (update) begin
      out_top         <= top_res;
      out_bot         <= bot_res;
      out_split_known <= split_valid_next;
      out_split_row   <= split_next;
      out_locked      <= lock_now;
    end
  end

  assign m_tdata = {out_split_row, out_bot.ys, out_bot.xs, out_top.ys, out_top.xs};
  assign m_tuser = {out_locked, out_split_known, out_bot.held, out_bot.present,
                    out_top.held, out_top.present};

  `DQCT_ASSERT_IMP(a_held_present, m_tvalid && (m_tuser[1] || m_tuser[3]),
    (!m_tuser[1] || m_tuser[0]) && (!m_tuser[3] || m_tuser[2]))
  `DQCT_ASSERT_IMP(a_absent_zero, m_tvalid && !m_tuser[0],
    m_tdata[127:0] == 128'd0)
  `DQCT_ASSERT_NEXT(a_locked_hold, m_tvalid && m_tuser[5],
    $stable(m_tdata) && $stable(m_tuser))

endmodule
